// ===== design/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and codes for the ARGB8888 pixel converter
// Field types, register indexes, pixel size and format codes, and the
// structs that run between the top level and the palette store.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  // Field types
  typedef logic [31:0] pixel_t;
  typedef logic [31:0] argb_t;
  typedef logic [23:0] rgb_t;
  typedef logic [15:0] chan16_t;
  typedef logic [7:0]  pal_idx_t;
  typedef logic [2:0]  src_bytes_t;
  typedef logic [3:0]  src_format_t;
  typedef logic [3:0]  cfg_idx_t;
  typedef logic [31:0] cfg_data_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_SRC_BYTES  = 4'd0;
  localparam cfg_idx_t CFG_SRC_FORMAT = 4'd1;

  // Source pixel sizes in bytes
  localparam src_bytes_t BYTES_1 = 3'd1;
  localparam src_bytes_t BYTES_2 = 3'd2;
  localparam src_bytes_t BYTES_3 = 3'd3;
  localparam src_bytes_t BYTES_4 = 3'd4;

  // Source formats
  localparam src_format_t FMT_INDEXED = 4'd0;
  localparam src_format_t FMT_RGB565  = 4'd1;
  localparam src_format_t FMT_BGR565  = 4'd2;
  localparam src_format_t FMT_RGB555  = 4'd3;
  localparam src_format_t FMT_XRGB888 = 4'd4;
  localparam src_format_t FMT_XBGR888 = 4'd5;
  localparam src_format_t FMT_RGBX888 = 4'd6;
  localparam src_format_t FMT_BGRX888 = 4'd7;
  localparam src_format_t FMT_XRGB666 = 4'd8;

  // Register reset values
  localparam src_bytes_t  SRC_BYTES_RST  = BYTES_4;
  localparam src_format_t SRC_FORMAT_RST = FMT_XRGB888;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_UNSUP = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // Palette write request
  typedef struct packed {
    logic     en;
    pal_idx_t idx;
    rgb_t     rgb;
  } pal_wr_t;

  // Palette read response (registered)
  typedef struct packed {
    logic hit;
    rgb_t rgb;
  } pal_rd_t;

endpackage

`default_nettype wire

// ===== design/pfa_ifs.sv =====
// ----------------------------------------------------------------------------
// pfa_ifs: valid/ready channel interfaces of the ARGB8888 pixel converter
// Input pixel channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: convert or palette load beats
interface pfa_in_if import pfa_pkg::*; ();
  logic     valid;
  logic     ready;
  logic     mode;
  pixel_t   pixel;
  pal_idx_t pal_index;
  chan16_t  red16;
  chan16_t  green16;
  chan16_t  blue16;

  modport source (output valid, mode, pixel, pal_index, red16, green16, blue16,
                  input ready);
  modport sink   (input valid, mode, pixel, pal_index, red16, green16, blue16,
                  output ready);
endinterface

// Result channel: converted pixels
interface pfa_out_if import pfa_pkg::*; ();
  logic  valid;
  logic  ready;
  argb_t argb;
  logic  status;

  modport source (output valid, argb, status, input ready);
  modport sink   (input valid, argb, status, output ready);
endinterface

// Configuration write channel
interface pfa_cfg_if import pfa_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/pfa_palette.sv =====
// ----------------------------------------------------------------------------
// pfa_palette: 24-bit palette store with registered read
// One write and one read port. Per-entry valid bits make unloaded entries
// read as misses, which the converter turns into black, straight after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_palette import pfa_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire pal_wr_t  wr,
  input  wire logic     rd_en,
  input  wire pal_idx_t rd_idx,
  output pal_rd_t       rd
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [8:0] DEPTH = 9'(ENTRIES);

  rgb_t               mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic               hit_r;
  rgb_t               rgb_r;

  logic          wr_in_range;
  logic          rd_in_range;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Index checks against the store depth
  assign wr_in_range = ({1'b0, wr.idx} < DEPTH);
  assign rd_in_range = ({1'b0, rd_idx} < DEPTH);
  assign wr_addr     = wr.idx[AW-1:0];
  assign rd_addr     = rd_idx[AW-1:0];

  // Storage array
  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr_addr] <= wr.rgb;
    end
    if (rd_en) begin
      rgb_r <= mem[rd_addr];
    end
  end

  // Valid bits and registered hit flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (wr.en && wr_in_range) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= rd_in_range && valid_r[rd_addr];
      end
    end
  end

  assign rd.hit = hit_r;
  assign rd.rgb = rgb_r;

endmodule

`default_nettype wire

// ===== design/pfa_convert.sv =====
// ----------------------------------------------------------------------------
// pfa_convert: source pixel to ARGB8888 datapath
// Field extraction, top-bit replication of narrow channels and byte
// reordering for every supported size and format pair.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_convert import pfa_pkg::*; (
  input  wire src_bytes_t  src_bytes,
  input  wire src_format_t src_format,
  input  wire pixel_t      pixel,
  input  wire pal_rd_t     pal,
  output argb_t            argb,
  output logic             status
);

  rgb_t rgb16;
  rgb_t rgb32;
  logic ok16;
  logic ok32;

  // 16-bit formats
  always_comb begin
    rgb16 = '0;
    ok16  = 1'b1;
    unique case (src_format)
      FMT_RGB565: begin
        rgb16 = {pixel[15:11], pixel[15:13], pixel[10:5], pixel[10:9],
                 pixel[4:0], pixel[4:2]};
      end
      FMT_BGR565: begin
        rgb16 = {pixel[4:0], pixel[4:2], pixel[10:5], pixel[10:9],
                 pixel[15:11], pixel[15:13]};
      end
      FMT_RGB555: begin
        rgb16 = {pixel[14:10], pixel[14:12], pixel[9:5], pixel[9:7],
                 pixel[4:0], pixel[4:2]};
      end
      default: begin
        ok16 = 1'b0;
      end
    endcase
  end

  // 24/32-bit formats
  always_comb begin
    rgb32 = '0;
    ok32  = 1'b1;
    unique case (src_format)
      FMT_XRGB888: rgb32 = pixel[23:0];
      FMT_XBGR888: rgb32 = {pixel[7:0], pixel[15:8], pixel[23:16]};
      FMT_RGBX888: rgb32 = pixel[31:8];
      FMT_BGRX888: rgb32 = {pixel[15:8], pixel[23:16], pixel[31:24]};
      FMT_XRGB666: begin
        rgb32 = {pixel[17:12], pixel[17:16], pixel[11:6], pixel[11:10],
                 pixel[5:0], pixel[5:4]};
      end
      default: begin
        ok32 = 1'b0;
      end
    endcase
  end

  // Size select; anything not handled reports unsupported with a zero word
  always_comb begin
    argb   = '0;
    status = STATUS_UNSUP;
    unique case (src_bytes)
      BYTES_1: begin
        if (src_format == FMT_INDEXED) begin
          argb   = {ALPHA_OPAQUE, pal.hit ? pal.rgb : rgb_t'(0)};
          status = STATUS_OK;
        end
      end
      BYTES_2: begin
        if (ok16) begin
          argb   = {ALPHA_OPAQUE, rgb16};
          status = STATUS_OK;
        end
      end
      BYTES_3, BYTES_4: begin
        if (ok32) begin
          argb   = {ALPHA_OPAQUE, rgb32};
          status = STATUS_OK;
        end
      end
      default: begin
        argb   = '0;
        status = STATUS_UNSUP;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/pixel_format_to_argb8888.sv =====
// ----------------------------------------------------------------------------
// pixel_format_to_argb8888: source pixel to opaque ARGB8888 converter
// Converts palette index, 565/555, 888 byte orders and 666 pixels to
// ARGB8888; load beats fill the 24-bit palette.
//
//   channel   dir   beat contents
//   -------   ---   ---------------------------------------------------
//   in_ch     in    mode, pixel, pal_index, red16, green16, blue16
//   out_ch    out   argb, status (one per convert beat, none per load)
//   cfg_ch    in    index, data (0 src_bytes, 1 src_format)
//
// One beat per clock in both directions while out_ch is not stalled.
// A convert beat passes the palette read register, then the result
// register, before it shows on out_ch. Load beats write the palette at
// acceptance. Reset clears the palette valid bits, so no clearing pass
// is needed. A stalled result holds the result register and the stage
// behind it; in_ch keeps accepting while either of the two stages is free.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_to_argb8888 import pfa_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pfa_in_if.sink      in_ch,
  pfa_out_if.source   out_ch,
  pfa_cfg_if.sink     cfg_ch
);

  src_bytes_t  src_bytes_r;
  src_format_t src_format_r;

  logic   s1_valid_r;
  logic   s1_valid_nxt;
  pixel_t s1_pixel_r;

  logic  out_valid_r;
  logic  out_valid_nxt;
  argb_t out_argb_r;
  logic  out_status_r;

  logic    advance;
  logic    in_beat;
  logic    conv_beat;
  pal_wr_t pal_wr;
  pal_rd_t pal_rd;
  argb_t   conv_argb;
  logic    conv_status;

  // Handshake control
  assign advance   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_beat   = in_ch.valid && in_ch.ready;
  assign conv_beat = in_beat && !in_ch.mode;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_bytes_r  <= SRC_BYTES_RST;
      src_format_r <= SRC_FORMAT_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == CFG_SRC_BYTES) begin
        src_bytes_r <= cfg_ch.data[2:0];
      end else if (cfg_ch.index == CFG_SRC_FORMAT) begin
        src_format_r <= cfg_ch.data[3:0];
      end
    end
  end

  // Palette store
  assign pal_wr.en  = in_beat && in_ch.mode;
  assign pal_wr.idx = in_ch.pal_index;
  assign pal_wr.rgb = {in_ch.red16[15:8], in_ch.green16[15:8], in_ch.blue16[15:8]};

  pfa_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (pal_wr),
    .rd_en  (conv_beat),
    .rd_idx (in_ch.pixel[7:0]),
    .rd     (pal_rd)
  );

  // Stage 1: accepted convert beat, palette read in flight
  always_comb begin
    if (conv_beat) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (conv_beat) begin
      s1_pixel_r <= in_ch.pixel;
    end
  end

  // Conversion datapath
  pfa_convert u_convert (
    .src_bytes  (src_bytes_r),
    .src_format (src_format_r),
    .pixel      (s1_pixel_r),
    .pal        (pal_rd),
    .argb       (conv_argb),
    .status     (conv_status)
  );

  // Stage 2: result register
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_argb_r   <= conv_argb;
      out_status_r <= conv_status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.argb   = out_argb_r;
  assign out_ch.status = out_status_r;

endmodule

`default_nettype wire
